/* rtl/odo_pkg.sv */
// Shared types, constants and the arctangent table for the odometry block.
package odo_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPEED,
    ST_RATE,
    ST_STEP,
    ST_HEAD,
    ST_DONE
  } odo_state_t;

  localparam logic [7:0] CFG_WHEEL_GAIN = 8'd0;
  localparam logic [7:0] CFG_INV_TRACK  = 8'd1;

  localparam logic signed [33:0] CORDIC_X0  = 34'sd652032874;
  localparam logic [31:0]        HEAD_SCALE = 32'd2867080570;
  localparam logic [29:0]        POS_DIV    = 30'd1024000000;

  localparam int DIV_W     = 66;
  localparam int DIV_STEPS = 37;

  localparam logic [5:0] PHASE_LAST = 6'd39;

  function automatic logic [31:0] odo_atan(input logic [4:0] idx);
    logic [31:0] v;
    begin
      unique case (idx)
        5'd0:  v = 32'h20000000;
        5'd1:  v = 32'h12E4051E;
        5'd2:  v = 32'h09FB385B;
        5'd3:  v = 32'h051111D4;
        5'd4:  v = 32'h028B0D43;
        5'd5:  v = 32'h0145D7E1;
        5'd6:  v = 32'h00A2F61E;
        5'd7:  v = 32'h00517C55;
        5'd8:  v = 32'h0028BE53;
        5'd9:  v = 32'h00145F2F;
        5'd10: v = 32'h000A2F98;
        5'd11: v = 32'h000517CC;
        5'd12: v = 32'h00028BE6;
        5'd13: v = 32'h000145F3;
        5'd14: v = 32'h0000A2FA;
        5'd15: v = 32'h0000517D;
        5'd16: v = 32'h000028BE;
        5'd17: v = 32'h0000145F;
        5'd18: v = 32'h00000A30;
        5'd19: v = 32'h00000518;
        5'd20: v = 32'h0000028C;
        5'd21: v = 32'h00000146;
        5'd22: v = 32'h000000A3;
        5'd23: v = 32'h00000051;
        5'd24: v = 32'h00000029;
        5'd25: v = 32'h00000014;
        5'd26: v = 32'h0000000A;
        5'd27: v = 32'h00000005;
        5'd28: v = 32'h00000003;
        5'd29: v = 32'h00000001;
        5'd30: v = 32'h00000001;
        default: v = 32'h00000000;
      endcase
      return v;
    end
  endfunction

endpackage

/* rtl/differential_drive_odometry_top.sv */
// Top level of the differential-drive odometry block: sequencer, registers and pose state.
//
//  Channel  Direction  Handshake                 Payload
//  in_      slave      in_tvalid / in_tready     in_tdata  (88 bits)
//  out_     master     out_tvalid / out_tready   out_tdata (192 bits)
//  cfg_     slave      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An item passes through four phases (speed, rate, step, heading), in which the bit-serial
// multipliers and, in the heading phase, the restoring divider work, and then a final step
// that updates the pose. The next item is taken in the idle state after that, so the block
// takes no new item until the last one is through. The CORDIC runs alongside the first phase.
// Reset clears the pose, the heading, the registers and all control state.
// A new item is taken only once the previous result has been loaded into the
// output register; a stall on the output holds the block in its last step.
module differential_drive_odometry_top
  import odo_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,   // left_motor_speed, right_motor_speed, elapsed_time, pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // position_x, position_y, heading_angle, forward_speed,
                                   // turn_rate
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  odo_state_t state_r, state_nxt;
  logic [5:0] cnt_r;

  logic [31:0] gain_r;
  logic [23:0] inv_r;

  logic signed [31:0] ml_r, mr_r;
  logic [19:0]        dt_r;
  logic signed [31:0] fwd_r;
  logic signed [32:0] diff_r;
  logic signed [31:0] turn_r;
  logic signed [45:0] tx_r, ty_r;
  logic signed [51:0] q_r;

  logic signed [47:0] pos_x_r, pos_y_r;
  logic [31:0]        heading_r;

  logic         out_valid_r;
  logic [191:0] out_data_r;

  logic in_acc, ph_start, ph_end, done_fire;

  logic signed [51:0] a0;
  logic [31:0]        b0;
  logic signed [45:0] a1, a2;
  logic [32:0]        b1, b2;
  logic               s1;
  logic signed [83:0] p0;
  logic signed [78:0] p1, p2;

  logic signed [33:0] cos_v, sin_v;
  logic signed [DIV_STEPS:0] qx, qy;

  logic signed [31:0] vl, vr;
  logic signed [32:0] vsum;
  logic signed [40:0] t41;
  logic signed [31:0] turn_sat;
  logic signed [48:0] px_sum, py_sum;
  logic signed [47:0] px_nxt, py_nxt;
  logic [31:0]        heading_nxt;

  assign in_acc    = in_tvalid && in_tready;
  assign ph_end    = (cnt_r == PHASE_LAST);
  assign done_fire = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_SPEED;
      ST_SPEED: if (ph_end) state_nxt = ST_RATE;
      ST_RATE:  if (ph_end) state_nxt = ST_STEP;
      ST_STEP:  if (ph_end) state_nxt = ST_HEAD;
      ST_HEAD:  if (ph_end) state_nxt = ST_DONE;
      ST_DONE:  if (done_fire) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    ph_start  = 1'b0;
    unique case (state_r)
      ST_IDLE:                             in_tready = 1'b1;
      ST_SPEED, ST_RATE, ST_STEP, ST_HEAD: ph_start  = (cnt_r == '0);
      ST_DONE:                             ph_start  = 1'b0;
      default:                             in_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
      inv_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WHEEL_GAIN: gain_r <= cfg_data;
        CFG_INV_TRACK:  inv_r  <= cfg_data[23:0];
        default:        ;
      endcase
    end
  end

  // Operand selection for the serial units
  always_comb begin
    a0 = '0;
    b0 = '0;
    a1 = '0;
    b1 = '0;
    s1 = 1'b0;
    a2 = '0;
    b2 = '0;
    unique case (state_r)
      ST_SPEED: begin
        a0 = 52'(ml_r);
        b0 = gain_r;
        a1 = 46'(mr_r);
        b1 = {1'b0, gain_r};
      end
      ST_RATE: begin
        a0 = 52'(diff_r);
        b0 = {8'd0, inv_r};
        a1 = 46'(cos_v);
        a2 = 46'(sin_v);
        b1 = 33'(fwd_r);
        b2 = 33'(fwd_r);
        s1 = 1'b1;
      end
      ST_STEP: begin
        a0 = 52'(turn_r);
        b0 = {12'd0, dt_r};
        a1 = tx_r;
        a2 = ty_r;
        b1 = {13'd0, dt_r};
        b2 = {13'd0, dt_r};
      end
      ST_HEAD: begin
        a0 = q_r;
        b0 = HEAD_SCALE;
      end
      default: ;
    endcase
  end

  odo_mul #(.WA(52), .WB(32)) u_mul0 (
    .clk(clk), .rst_n(rst_n), .start(ph_start), .b_sgn(1'b0),
    .a(a0), .b(b0), .prod(p0)
  );

  odo_mul #(.WA(46), .WB(33)) u_mul1 (
    .clk(clk), .rst_n(rst_n), .start(ph_start), .b_sgn(s1),
    .a(a1), .b(b1), .prod(p1)
  );

  odo_mul #(.WA(46), .WB(33)) u_mul2 (
    .clk(clk), .rst_n(rst_n), .start(ph_start), .b_sgn(s1),
    .a(a2), .b(b2), .prod(p2)
  );

  odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(ph_start && (state_r == ST_SPEED)),
    .angle(heading_r), .cos_o(cos_v), .sin_o(sin_v)
  );

  odo_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(ph_start && (state_r == ST_HEAD)),
    .num(p1[DIV_W-1:0]), .quo(qx)
  );

  odo_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(ph_start && (state_r == ST_HEAD)),
    .num(p2[DIV_W-1:0]), .quo(qy)
  );

  always_comb begin
    vl   = p0[63:32];
    vr   = p1[63:32];
    vsum = 33'(vl) + 33'(vr);
    t41  = p0[56:16];
    if (t41 > 41'sd2147483647) begin
      turn_sat = 32'sh7FFFFFFF;
    end else if (t41 < -41'sd2147483648) begin
      turn_sat = 32'sh80000000;
    end else begin
      turn_sat = t41[31:0];
    end
    px_sum = 49'(pos_x_r) + 49'(qx);
    py_sum = 49'(pos_y_r) + 49'(qy);
    if (px_sum[48] != px_sum[47]) begin
      px_nxt = px_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      px_nxt = px_sum[47:0];
    end
    if (py_sum[48] != py_sum[47]) begin
      py_nxt = py_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      py_nxt = py_sum[47:0];
    end
    heading_nxt = heading_r + p0[69:38];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ml_r <= in_tdata[31:0];
      mr_r <= in_tdata[63:32];
      dt_r <= in_tdata[83:64];
    end
    if (ph_end && (state_r == ST_SPEED)) begin
      fwd_r  <= vsum[32:1];
      diff_r <= 33'(vr) - 33'(vl);
    end
    if (ph_end && (state_r == ST_RATE)) begin
      turn_r <= turn_sat;
      tx_r   <= p1[65:20];
      ty_r   <= p2[65:20];
    end
    if (ph_end && (state_r == ST_STEP)) begin
      q_r <= p0[51:0];
    end
    if (done_fire) begin
      out_data_r <= {turn_r, fwd_r, heading_nxt, py_nxt, px_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (done_fire) begin
        pos_x_r   <= px_nxt;
        pos_y_r   <= py_nxt;
        heading_r <= heading_nxt;
      end
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SPEED))
    else $error("accepted transfer did not start the speed phase");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished item did not reach the output register");

  a_heading_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(heading_r)) |-> $past(state_r == ST_DONE))
    else $error("heading changed outside the update step");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("input ready while an item is in progress");
`endif

endmodule

/* rtl/odo_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module odo_mul #(
  parameter int WA = 52,
  parameter int WB = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       b_sgn,
  input  logic signed [WA-1:0]       a,
  input  logic        [WB-1:0]       b,
  output logic signed [WA+WB-1:0]    prod
);

  localparam int CW = $clog2(WB + 1);

  logic signed [WA-1:0] a_r;
  logic        [WB-1:0] b_r;
  logic signed [WA:0]   hi_r;
  logic        [WB-1:0] lo_r;
  logic                 sgn_r;
  logic        [CW-1:0] cnt_r;

  logic signed [WA:0]   a_ext;
  logic signed [WA:0]   addend;
  logic signed [WA:0]   sum;
  logic                 last;
  logic signed [WA:0]   hi_nxt;
  logic        [WB-1:0] lo_nxt;

  always_comb begin
    a_ext  = $signed({a_r[WA-1], a_r});
    last   = (cnt_r == CW'(WB - 1));
    addend = '0;
    if (b_r[0]) begin
      addend = (last && sgn_r) ? -a_ext : a_ext;
    end
    sum    = hi_r + addend;
    hi_nxt = $signed({sum[WA], sum[WA:1]});
    lo_nxt = {sum[0], lo_r[WB-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CW'(WB);
    end else if (start) begin
      cnt_r <= '0;
    end else if (cnt_r != CW'(WB)) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      sgn_r <= b_sgn;
      hi_r  <= '0;
      lo_r  <= '0;
    end else if (cnt_r != CW'(WB)) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
      b_r  <= {1'b0, b_r[WB-1:1]};
    end
  end

  assign prod = $signed({hi_r[WA-1:0], lo_r});

endmodule

/* rtl/odo_cordic.sv */
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module odo_cordic
  import odo_pkg::*;
#(
  parameter int STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [32:0] z_r;
  logic               flip_r;
  logic [5:0]         cnt_r;

  logic               flip;
  logic [31:0]        h;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [32:0] at;

  always_comb begin
    flip = angle[31] ^ angle[30];
    h    = flip ? {~angle[31], angle[30:0]} : angle;
    xs   = x_r >>> cnt_r[4:0];
    ys   = y_r >>> cnt_r[4:0];
    at   = $signed({1'b0, odo_atan(cnt_r[4:0])});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'(STEPS);
    end else if (start) begin
      cnt_r <= '0;
    end else if (cnt_r != 6'(STEPS)) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_X0;
      y_r    <= '0;
      z_r    <= $signed({h[31], h});
      flip_r <= flip;
    end else if (cnt_r != 6'(STEPS)) begin
      if (!z_r[32]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;

endmodule

/* rtl/odo_div.sv */
// Bit-serial restoring division of a signed value by the position scale, truncating.
module odo_div
  import odo_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [DIV_W-1:0]   num,
  output logic signed [DIV_STEPS:0] quo
);

  logic [29:0]          rem_r;
  logic [DIV_STEPS-1:0] sh_r;
  logic                 neg_r;
  logic [5:0]           cnt_r;

  logic [DIV_W-1:0]     mag;
  logic [30:0]          t;
  logic                 ge;
  logic [30:0]          diff;

  always_comb begin
    mag  = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
    t    = {rem_r, sh_r[DIV_STEPS-1]};
    ge   = (t >= {1'b0, POS_DIV});
    diff = t - {1'b0, POS_DIV};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'(DIV_STEPS);
    end else if (start) begin
      cnt_r <= '0;
    end else if (cnt_r != 6'(DIV_STEPS)) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 30'(mag[DIV_W-1:DIV_STEPS]);
      sh_r  <= mag[DIV_STEPS-1:0];
      neg_r <= num[DIV_W-1];
    end else if (cnt_r != 6'(DIV_STEPS)) begin
      rem_r <= ge ? diff[29:0] : t[29:0];
      sh_r  <= {sh_r[DIV_STEPS-2:0], ge};
    end
  end

  assign quo = neg_r ? -$signed({1'b0, sh_r}) : $signed({1'b0, sh_r});

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the differential-drive odometry block, with a pose predictor.
module testbench;
  import odo_pkg::*;

  localparam int STEP_COUNT  = 24;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [7:0] CFG_SPARE = 8'd2;
  localparam logic [7:0] CFG_TOP   = 8'hFF;
  localparam longint POS_HI   = 64'sh00007FFFFFFFFFFF;
  localparam longint POS_LO   = -POS_HI - 1;
  localparam longint RATE_HI  = 64'sh000000007FFFFFFF;
  localparam longint RATE_LO  = -RATE_HI - 1;
  localparam longint MICRO_DIV = 1024000000;
  localparam longint ANGLE_SCALE = 64'sd2867080570;

  localparam logic [31:0] ARC_TABLE [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct {
    logic [47:0] pos_x;
    logic [47:0] pos_y;
    logic [31:0] heading;
    logic [31:0] fwd;
    logic [31:0] turn;
  } pose_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] a;
    logic [31:0] b;
    logic [19:0] dt;
    logic        zero_result;
  } row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [87:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [31:0] wheel_gain_q;
  logic [23:0] inv_track_q;
  longint pose_x_q, pose_y_q;
  logic [31:0] heading_q;

  pose_t expected_poses[$];
  int mismatches = 0;
  int cycles = 0;
  int hold_off = 0;
  bit gaps_on = 1'b1;

  differential_drive_odometry_top #(.CORDIC_STEPS(STEP_COUNT)) DUT (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void heading_trig(input logic [31:0] ang, output longint c,
                                       output longint s);
    logic flip;
    logic [31:0] h;
    logic [31:0] probe;
    longint x, y, z, xs, ys;
    probe = ang + 32'h40000000;
    flip = probe[31];
    h = flip ? ang + 32'h80000000 : ang;
    z = longint'($signed(h));
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEP_COUNT && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= longint'(ARC_TABLE[i]);
      end else begin
        x += ys;
        y -= xs;
        z += longint'(ARC_TABLE[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic pose_t advance_pose(logic [31:0] left, logic [31:0] right,
                                         logic [19:0] dt_us);
    longint ml, mr, dt, vl, vr, fwd, turn, c, s, q, qh, ql, dh;
    pose_t res;
    ml = longint'($signed(left));
    mr = longint'($signed(right));
    dt = longint'(dt_us);
    vl = (ml * longint'(wheel_gain_q)) >>> 32;
    vr = (mr * longint'(wheel_gain_q)) >>> 32;
    fwd = clamp((vl + vr) >>> 1, RATE_LO, RATE_HI);
    turn = clamp(((vr - vl) * longint'(inv_track_q)) >>> 16, RATE_LO, RATE_HI);
    heading_trig(heading_q, c, s);
    pose_x_q = clamp(pose_x_q + (((fwd * c) >>> 20) * dt) / MICRO_DIV, POS_LO, POS_HI);
    pose_y_q = clamp(pose_y_q + (((fwd * s) >>> 20) * dt) / MICRO_DIV, POS_LO, POS_HI);
    q = turn * dt;
    qh = q >>> 21;
    ql = q - (qh <<< 21);
    dh = (qh * ANGLE_SCALE + ((ql * ANGLE_SCALE) >>> 21)) >>> 17;
    heading_q = heading_q + dh[31:0];
    res.pos_x = pose_x_q[47:0];
    res.pos_y = pose_y_q[47:0];
    res.heading = heading_q;
    res.fwd = fwd[31:0];
    res.turn = turn[31:0];
    return res;
  endfunction

  task automatic report(string field, logic [47:0] got, logic [47:0] want);
    $display("t=%0t %s: got %h, expected %h", $time, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pose_t want;
    if (out_tvalid && out_tready) begin
      if (expected_poses.size() == 0) begin
        report("unexpected transfer", out_tdata[47:0], '0);
      end else begin
        want = expected_poses.pop_front();
        if (out_tdata[47:0] !== want.pos_x) report("position_x", out_tdata[47:0], want.pos_x);
        if (out_tdata[95:48] !== want.pos_y) report("position_y", out_tdata[95:48], want.pos_y);
        if (out_tdata[127:96] !== want.heading)
          report("heading_angle", 48'(out_tdata[127:96]), 48'(want.heading));
        if (out_tdata[159:128] !== want.fwd)
          report("forward_speed", 48'(out_tdata[159:128]), 48'(want.fwd));
        if (out_tdata[191:160] !== want.turn)
          report("turn_rate", 48'(out_tdata[191:160]), 48'(want.turn));
      end
    end
  end

  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_tready <= 1'b0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      stall = gaps_on ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic send_item(logic [31:0] left, logic [31:0] right, logic [19:0] dt_us,
                           bit zero_result);
    int gap;
    pose_t res;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, dt_us, right, left};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = advance_pose(left, right, dt_us);
    if (zero_result) res = '{default: '0};
    expected_poses.push_back(res);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] value);
    in_tvalid <= 1'b0;
    while (expected_poses.size() != 0) @(negedge clk);
    repeat (170) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_WHEEL_GAIN) wheel_gain_q = value;
    else if (idx == CFG_INV_TRACK) inv_track_q = value[23:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  row_t directed[] = '{
    '{ROW_ITEM, 32'h7FFFFFFF, 32'h80000000, 20'hFFFFF, 1'b1},
    '{ROW_ITEM, 32'h80000000, 32'h7FFFFFFF, 20'h00000, 1'b1},
    '{ROW_CFG,  32'(CFG_WHEEL_GAIN), 32'hFFFFFFFF, 20'h0, 1'b0},
    '{ROW_CFG,  32'(CFG_INV_TRACK),  32'hFFFFFFFF, 20'h0, 1'b0},
    '{ROW_CFG,  32'(CFG_SPARE),      32'h12345678, 20'h0, 1'b0},
    '{ROW_CFG,  32'(CFG_TOP),        32'hDEADBEEF, 20'h0, 1'b0},
    '{ROW_ITEM, 32'h7FFFFFFF, 32'h7FFFFFFF, 20'hFFFFF, 1'b0},
    '{ROW_ITEM, 32'h80000000, 32'h80000000, 20'hFFFFF, 1'b0},
    '{ROW_ITEM, 32'h80000000, 32'h7FFFFFFF, 20'h00000, 1'b0},
    '{ROW_ITEM, 32'h7FFFFFFF, 32'h80000000, 20'hFFFFF, 1'b0},
    '{ROW_ITEM, 32'h00010000, 32'h00000000, 20'h00001, 1'b0},
    '{ROW_ITEM, 32'hFFFFFFFF, 32'h00000001, 20'h7A120, 1'b0},
    '{ROW_CFG,  32'(CFG_WHEEL_GAIN), 32'h10000000, 20'h0, 1'b0},
    '{ROW_CFG,  32'(CFG_INV_TRACK),  32'h00030000, 20'h0, 1'b0},
    '{ROW_ITEM, 32'hFFF00000, 32'h00100000, 20'hFFFFF, 1'b0},
    '{ROW_ITEM, 32'hFFF00000, 32'h00100000, 20'hFFFFF, 1'b0},
    '{ROW_ITEM, 32'hFFF00000, 32'h00100000, 20'hFFFFF, 1'b0},
    '{ROW_ITEM, 32'h00100000, 32'h00300000, 20'hFFFFF, 1'b0},
    '{ROW_ITEM, 32'h00200000, 32'h00200000, 20'h00000, 1'b0},
    '{ROW_ITEM, 32'h00100000, 32'hFFF00000, 20'hFFFFF, 1'b0}
  };

  logic [31:0] phase_gain [6] = '{32'hFFFFFFFF, 32'h0, 32'h00400000, 32'h0, 32'h80000000, 32'h0};
  logic [31:0] phase_track [6] = '{32'hFFFFFF, 32'h010000, 32'h01C000, 32'h0, 32'h000001, 32'h0};

  initial begin
    logic [31:0] left, right;
    logic [19:0] dt_us;
    int pick;
    wheel_gain_q = '0;
    inv_track_q = '0;
    pose_x_q = 0;
    pose_y_q = 0;
    heading_q = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) write_reg(directed[i].a[7:0], directed[i].b);
      else send_item(directed[i].a, directed[i].b, directed[i].dt, directed[i].zero_result);
    end
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_WHEEL_GAIN, ph == 3 || ph == 5 ? $urandom : phase_gain[ph]);
      write_reg(CFG_INV_TRACK, ph == 3 || ph == 5 ? $urandom : phase_track[ph]);
      gaps_on = (ph != 3);
      if (ph == 2) hold_off = 700;
      for (int n = 0; n < 184; n++) begin
        pick = $urandom_range(0, 9);
        left = $urandom;
        right = $urandom;
        if (pick >= 6 && pick <= 7) begin
          left = $urandom_range(0, 32'h001FFFFF) - 32'h00100000;
          right = $urandom_range(0, 32'h001FFFFF) - 32'h00100000;
        end else if (pick == 8) begin
          right = left;
        end else if (pick == 9) begin
          left = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
          right = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
        end
        case ($urandom_range(0, 7))
          0: dt_us = '0;
          1: dt_us = 20'hFFFFF;
          default: dt_us = 20'($urandom_range(0, 20'hFFFFF));
        endcase
        send_item(left, right, dt_us, 1'b0);
      end
    end
    in_tvalid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
